// File: hdl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// Decompression tissue tracker package
// Shared types, command codes, compartment tables and build-time uptake
// factors for the trimix tissue tracker.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Build-time configuration.
  localparam int DTT_COMPARTMENTS = 16;
  localparam int TICK_SECONDS     = 1;
  localparam int TAB_DEPTH        = 16;
  localparam int TAB_IDX_W        = 4;

  // Fixed-point constants (pressures in 1/4096 bar).
  localparam logic [17:0] LOAD_MAX    = 18'h3FFFF;
  localparam int          ONE_BAR     = 4096;
  localparam logic [17:0] N2_RESET    = 18'(((4096 - 257) * 51786) / 65536);
  localparam longint unsigned LN2_Q32 = 64'd2977044472;

  // Shared divider widths.
  localparam int DIV_N = 52;
  localparam int DIV_D = 33;

  // Register reset values and indexes.
  localparam logic [9:0] WVP_RESET  = 10'd257;
  localparam logic [3:0] STOP_RESET = 4'd3;
  localparam logic [4:0] LAST_RESET = 5'd3;
  localparam logic [1:0] REG_WVP    = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_LAST   = 2'd2;

  // Half-times in hundredths of a minute.
  localparam int unsigned HT_N2 [TAB_DEPTH] = '{
    500, 800, 1250, 1850, 2700, 3830, 5430, 7700,
    10900, 14600, 18700, 23900, 30500, 39000, 49800, 63500};
  localparam int unsigned HT_HE [TAB_DEPTH] = '{
    188, 302, 472, 699, 1021, 1448, 2053, 2911,
    4120, 5519, 7069, 9034, 11529, 14742, 18824, 24003};

  // M-value coefficients scaled by 10000.
  localparam logic [13:0] A_N2 [TAB_DEPTH] = '{
    14'd11696, 14'd10000, 14'd8618, 14'd7562, 14'd6667, 14'd5933, 14'd5282, 14'd4701,
    14'd4187, 14'd3798, 14'd3497, 14'd3223, 14'd2971, 14'd2737, 14'd2523, 14'd2327};
  localparam logic [13:0] B_N2 [TAB_DEPTH] = '{
    14'd5578, 14'd6514, 14'd7222, 14'd7825, 14'd8126, 14'd8434, 14'd8693, 14'd8910,
    14'd9092, 14'd9222, 14'd9319, 14'd9403, 14'd9477, 14'd9544, 14'd9602, 14'd9653};
  localparam logic [13:0] A_HE [TAB_DEPTH] = '{
    14'd16189, 14'd13830, 14'd11919, 14'd10458, 14'd9220, 14'd8205, 14'd7305, 14'd6502,
    14'd5950, 14'd5545, 14'd5333, 14'd5189, 14'd5181, 14'd5176, 14'd5172, 14'd5119};
  localparam logic [13:0] B_HE [TAB_DEPTH] = '{
    14'd4770, 14'd5747, 14'd6527, 14'd7223, 14'd7582, 14'd7957, 14'd8279, 14'd8553,
    14'd8757, 14'd8903, 14'd8997, 14'd9073, 14'd9122, 14'd9171, 14'd9217, 14'd9267};

  typedef logic [TAB_DEPTH-1:0][31:0] uptake_tab_t;

  // Truncating long division by shift and subtract, for elaboration-time values.
  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q32 uptake factor 1 - 2^(-tick/halftime), evaluated at elaboration only.
  function automatic logic [31:0] uptake_q32(input bit he, input int idx);
    longint unsigned den;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    den  = 64'd60 * longint'(he ? HT_HE[idx] : HT_N2[idx]);
    x    = const_div(LN2_Q32 * longint'(TICK_SECONDS) * 64'd100 + (den >> 1), den);
    if (x > 64'hFFFF_FFFF) begin
      x = 64'hFFFF_FFFF;
    end
    term = x;
    sum  = 64'd0;
    for (int n = 1; n <= 32; n++) begin
      if (term != 64'd0) begin
        if ((n & 1) == 1) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
        term = const_div((term * x) >> 32, 64'(n + 1));
      end
    end
    return sum[31:0];
  endfunction

  function automatic uptake_tab_t make_uptake_tab(input bit he);
    uptake_tab_t t;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      t[i] = uptake_q32(he, i);
    end
    return t;
  endfunction

  localparam uptake_tab_t UPTAKE_N2 = make_uptake_tab(1'b0);
  localparam uptake_tab_t UPTAKE_HE = make_uptake_tab(1'b1);

  // Payload types.
  typedef struct packed {
    logic [11:0] depth_dm;
    logic [15:0] oxygen_fraction;
    logic [15:0] helium_fraction;
    logic [13:0] loop_ppo2;
    logic        source_valid;
    logic        advance;
  } in_t;

  typedef struct packed {
    logic [7:0] ceiling_m;
    logic       tissues_updated;
  } out_t;

  typedef struct packed {
    logic [9:0] water_vapour_pressure;
    logic [3:0] stop_increment_m;
    logic [4:0] last_stop_depth_m;
  } cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_AMB,
    OP_INERT,
    OP_DIV_HE,
    OP_SPLIT,
    OP_MUL_N,
    OP_WR_N,
    OP_MUL_H,
    OP_WR_H,
    OP_CLR_MAX,
    OP_MAC_AN,
    OP_MAC_AH,
    OP_MAC_BN,
    OP_MAC_BH,
    OP_DIV_AP,
    OP_TAKE_AP,
    OP_DIV_C,
    OP_TAKE_C,
    OP_DIV_K,
    OP_CEIL,
    OP_PUSH
  } dtt_op_t;

  typedef struct packed {
    dtt_op_t              op;
    logic [TAB_IDX_W-1:0] idx;
  } dtt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pt_zero;
    logic c_skip;
    logic maxc_le_bar;
  } dtt_status_t;

endpackage

// File: hdl/decompression_tissue_tracker.sv
// ----------------------------------------------------------------------------
// Decompression tissue tracker
// Trimix tissue model with sixteen-compartment relaxation and a weighted
// M-value ceiling, rounded to the stop grid.
// ----------------------------------------------------------------------------
// Tissues advance only for a request with a valid source and the advance flag,
// else they hold; an empty compartment skips both divisions of the ceiling walk,
// a safe one the second, and a stalled result holds the controller at its output.
// Requests are taken one at a time; the shared 52-step restoring divider, used
// twice per compartment, also serves the pressure split and the stop rounding.
// Reset: synchronous; loadings to surface air equilibrium, registers to defaults.
module decompression_tissue_tracker import dtt_pkg::*; #(
  parameter int COMPARTMENTS = DTT_COMPARTMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  dtt_cmd_t    cmd;
  dtt_status_t status;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.water_vapour_pressure <= WVP_RESET;
      cfg.stop_increment_m      <= STOP_RESET;
      cfg.last_stop_depth_m     <= LAST_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WVP:  cfg.water_vapour_pressure <= pwdata[9:0];
        REG_STOP: cfg.stop_increment_m      <= pwdata[3:0];
        REG_LAST: cfg.last_stop_depth_m     <= pwdata[4:0];
        default:  cfg.last_stop_depth_m     <= cfg.last_stop_depth_m;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_WVP:  prdata = {22'd0, cfg.water_vapour_pressure};
      REG_STOP: prdata = {28'd0, cfg.stop_increment_m};
      REG_LAST: prdata = {27'd0, cfg.last_stop_depth_m};
      default:  prdata = 32'd0;
    endcase
  end

  dtt_ctrl #(
    .COMPARTMENTS (COMPARTMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_update (in_data.source_valid & in_data.advance),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtt_datapath #(
    .COMPARTMENTS (COMPARTMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg),
    .status   (status),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // A request is worked on alone: no second request right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in progress");

  // A stop increment write lands in its register.
  a_stop_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && reg_idx == REG_STOP) |=> (cfg.stop_increment_m == $past(pwdata[3:0])))
    else $error("stop increment register not written");
`endif

endmodule

// File: hdl/dtt_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses for one cycle
// when the quotient register is final.
// ----------------------------------------------------------------------------
module dtt_div import dtt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic [DIV_N-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_N);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_N-1:0] dvd;
  logic [DIV_D-1:0] dsr;
  logic [DIV_D-1:0] rem;
  logic [DIV_D:0]   trial;
  logic             fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem, dvd[DIV_N-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Iteration control and shift registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DIV_N-2:0], 1'b0};
      rem      <= fits ? DIV_D'(trial - {1'b0, dsr}) : trial[DIV_D-1:0];
      quotient <= {quotient[DIV_N-2:0], fits};
    end
  end

endmodule

// File: hdl/dtt_datapath.sv
// ----------------------------------------------------------------------------
// Tissue tracker datapath
// Holds the tissue loadings, the inspired pressure split, the relaxation
// multiplier, the M-value accumulation and the shared divider.
// ----------------------------------------------------------------------------
module dtt_datapath import dtt_pkg::*; #(
  parameter int COMPARTMENTS = DTT_COMPARTMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  dtt_cmd_t    cmd,
  input  in_t         in_data,
  input  cfg_t        cfg,
  output dtt_status_t status,
  output out_t        out_data
);

  localparam int IDX_W = (COMPARTMENTS > 1) ? $clog2(COMPARTMENTS) : 1;
  // ceil(2^32/25): exact quotient by 25 for every dividend below 2^22.
  localparam logic [27:0] AMB_RECIP = 28'd171798692;

  logic [IDX_W-1:0] idx;
  logic [17:0]      ln [COMPARTMENTS];
  logic [17:0]      lh [COMPARTMENTS];

  in_t         in_q;
  logic        upd;
  logic [17:0] inert;
  logic [17:0] phe;
  logic [17:0] pn2;
  logic [49:0] prod;
  logic        neg;
  logic [18:0] pt;
  logic [32:0] aw;
  logic [32:0] bw;
  logic [18:0] ap;
  logic [18:0] maxc;
  logic [7:0]  ceil_res;
  logic [17:0] amb_q;

  logic             div_start;
  logic [DIV_N-1:0] div_dividend;
  logic [DIV_D-1:0] div_divisor;
  logic [DIV_N-1:0] quo;
  logic             div_done;

  assign idx = cmd.idx[IDX_W-1:0];

  dtt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  // Current compartment loadings.
  logic [17:0] cur_n;
  logic [17:0] cur_h;
  assign cur_n = ln[idx];
  assign cur_h = lh[idx];

  // Relaxation towards the inspired pressure of the selected gas.
  logic        is_he;
  logic [17:0] rlx_cur;
  logic [17:0] rlx_tgt;
  logic [31:0] rlx_f;
  logic        diff_neg;
  logic [17:0] diff_mag;
  logic [49:0] prod_next;
  logic [50:0] round_sum;
  logic [18:0] step;
  logic [19:0] up_sum;
  logic [17:0] rlx_val;

  assign is_he     = (cmd.op == OP_MUL_H) || (cmd.op == OP_WR_H);
  assign rlx_cur   = is_he ? cur_h : cur_n;
  assign rlx_tgt   = is_he ? phe : pn2;
  assign rlx_f     = is_he ? UPTAKE_HE[cmd.idx] : UPTAKE_N2[cmd.idx];
  assign diff_neg  = rlx_tgt < rlx_cur;
  assign diff_mag  = diff_neg ? (rlx_cur - rlx_tgt) : (rlx_tgt - rlx_cur);
  assign prod_next = {32'd0, diff_mag} * {18'd0, rlx_f};
  assign round_sum = {1'b0, prod} + 51'h0_8000_0000;
  assign step      = round_sum[50:32];
  assign up_sum    = {2'b00, rlx_cur} + {1'b0, step};

  always_comb begin
    if (neg) begin
      rlx_val = ({1'b0, rlx_cur} < step) ? 18'd0 : 18'({1'b0, rlx_cur} - step);
    end else begin
      rlx_val = (up_sum > {2'b00, LOAD_MAX}) ? LOAD_MAX : up_sum[17:0];
    end
  end

  // Depth in bar: the rounded quotient by 100 is taken as a quarter divided
  // by 25 through a reciprocal multiplication.
  logic [23:0] amb_num;
  logic [49:0] amb_prod;
  assign amb_num  = {in_q.depth_dm, 12'd0} + 24'd50;
  assign amb_prod = {28'd0, amb_num[23:2]} * {22'd0, AMB_RECIP};

  // Ambient and inert pressure.
  logic [17:0] amb;
  logic [17:0] sub_p;
  logic [16:0] dry;
  logic [33:0] he_prod;
  assign amb     = 18'(ONE_BAR) + amb_q;
  assign sub_p   = {8'd0, cfg.water_vapour_pressure} + {4'd0, in_q.loop_ppo2};
  assign dry     = 17'h1_0000 - {1'b0, in_q.oxygen_fraction};
  assign he_prod = {16'd0, inert} * {18'd0, in_q.helium_fraction};

  // M-value terms.
  logic [32:0] pt_den;
  logic [18:0] pt_sub;
  logic [51:0] c_prod;
  logic [18:0] c_val;
  assign pt_den = {14'd0, pt} * 33'd10000;
  assign pt_sub = pt - ap;
  assign c_prod = {33'd0, pt_sub} * {19'd0, bw};
  assign c_val  = quo[18:0];

  // Ceiling rounding to the stop grid.
  logic [3:0]  stop_eff;
  logic [15:0] den_k;
  logic [23:0] k_num;
  logic [14:0] ceil15;
  logic [14:0] ceil_lo;
  assign stop_eff = (cfg.stop_increment_m == 4'd0) ? 4'd1 : cfg.stop_increment_m;
  assign den_k    = {stop_eff, 12'd0};
  assign k_num    = {5'd0, maxc - 19'(ONE_BAR)} * 24'd10 + {8'd0, den_k} - 24'd1;
  assign ceil15   = {4'd0, quo[10:0]} * {11'd0, stop_eff};
  assign ceil_lo  = (ceil15 < {10'd0, cfg.last_stop_depth_m}) ?
                    {10'd0, cfg.last_stop_depth_m} : ceil15;

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      OP_DIV_HE: begin
        div_start    = 1'b1;
        div_dividend = {18'd0, he_prod};
        div_divisor  = {16'd0, dry};
      end
      OP_DIV_AP: begin
        div_start    = 1'b1;
        div_dividend = {7'd0, aw, 12'd0};
        div_divisor  = pt_den;
      end
      OP_DIV_C: begin
        div_start    = 1'b1;
        div_dividend = c_prod;
        div_divisor  = pt_den;
      end
      OP_DIV_K: begin
        div_start    = 1'b1;
        div_dividend = {28'd0, k_num};
        div_divisor  = {17'd0, den_k};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Tissue loadings, cleared to the surface equilibrium by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMPARTMENTS; i++) begin
        ln[i] <= N2_RESET;
        lh[i] <= 18'd0;
      end
    end else if (cmd.op == OP_WR_N) begin
      ln[idx] <= rlx_val;
    end else if (cmd.op == OP_WR_H) begin
      lh[idx] <= rlx_val;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_q <= in_data;
        upd  <= in_data.source_valid & in_data.advance;
      end
      OP_DIV_AMB: begin
        amb_q <= amb_prod[49:32];
      end
      OP_INERT: begin
        inert <= (amb > sub_p) ? (amb - sub_p) : 18'd0;
      end
      OP_SPLIT: begin
        phe <= (quo > {34'd0, inert}) ? inert : quo[17:0];
        pn2 <= (quo > {34'd0, inert}) ? 18'd0 : (inert - quo[17:0]);
      end
      OP_MUL_N, OP_MUL_H: begin
        prod <= prod_next;
        neg  <= diff_neg;
      end
      OP_CLR_MAX: begin
        maxc <= 19'd0;
      end
      OP_MAC_AN: begin
        aw <= {19'd0, A_N2[cmd.idx]} * {15'd0, cur_n};
        pt <= {1'b0, cur_n} + {1'b0, cur_h};
      end
      OP_MAC_AH: begin
        aw <= aw + {19'd0, A_HE[cmd.idx]} * {15'd0, cur_h};
      end
      OP_MAC_BN: begin
        bw <= {19'd0, B_N2[cmd.idx]} * {15'd0, cur_n};
      end
      OP_MAC_BH: begin
        bw <= bw + {19'd0, B_HE[cmd.idx]} * {15'd0, cur_h};
      end
      OP_TAKE_AP: begin
        ap <= quo[18:0];
      end
      OP_TAKE_C: begin
        if (c_val > maxc) begin
          maxc <= c_val;
        end
      end
      OP_CEIL: begin
        if (maxc <= 19'(ONE_BAR)) begin
          ceil_res <= 8'd0;
        end else begin
          ceil_res <= (ceil_lo > 15'd255) ? 8'd255 : ceil_lo[7:0];
        end
      end
      OP_PUSH: begin
        out_data <= '{ceiling_m: ceil_res, tissues_updated: upd};
      end
      default: begin
        upd <= upd;
      end
    endcase
  end

  // Status back to the controller.
  assign status.div_done    = div_done;
  assign status.pt_zero     = (pt == 19'd0);
  assign status.c_skip      = (pt <= ap);
  assign status.maxc_le_bar = (maxc <= 19'(ONE_BAR));

endmodule

// File: hdl/dtt_ctrl.sv
// ----------------------------------------------------------------------------
// Tissue tracker controller
// Sequences the pressure split, the per-compartment relaxation, the
// ceiling walk and the output handshake.
// ----------------------------------------------------------------------------
module dtt_ctrl import dtt_pkg::*; #(
  parameter int COMPARTMENTS = DTT_COMPARTMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_update,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dtt_status_t status,
  output dtt_cmd_t    cmd
);

  localparam int IDX_W = (COMPARTMENTS > 1) ? $clog2(COMPARTMENTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(COMPARTMENTS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_AMB, S_AMB_W, S_HE, S_HE_W,
    S_MUL_N, S_WR_N, S_MUL_H, S_WR_H,
    S_CLR, S_AN, S_AH, S_BN, S_BH, S_CHK, S_AP_W, S_CK2, S_C_W, S_NEXT,
    S_KS, S_K_W, S_OUT
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  dtt_op_t          op;
  logic             push;

  assign in_ready = (state == S_IDLE);
  assign push     = (state == S_OUT) && (!out_valid || out_ready);
  assign cmd.op   = op;
  assign cmd.idx  = TAB_IDX_W'(idx);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = in_update ? S_AMB : S_CLR;
        end
      end
      S_AMB: begin
        op         = OP_DIV_AMB;
        state_next = S_AMB_W;
      end
      S_AMB_W: begin
        op         = OP_INERT;
        state_next = S_HE;
      end
      S_HE: begin
        op         = OP_DIV_HE;
        state_next = S_HE_W;
      end
      S_HE_W: begin
        if (status.div_done) begin
          op         = OP_SPLIT;
          idx_next   = '0;
          state_next = S_MUL_N;
        end
      end
      S_MUL_N: begin
        op         = OP_MUL_N;
        state_next = S_WR_N;
      end
      S_WR_N: begin
        op         = OP_WR_N;
        state_next = S_MUL_H;
      end
      S_MUL_H: begin
        op         = OP_MUL_H;
        state_next = S_WR_H;
      end
      S_WR_H: begin
        op = OP_WR_H;
        if (idx == LAST) begin
          state_next = S_CLR;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_MUL_N;
        end
      end
      S_CLR: begin
        op         = OP_CLR_MAX;
        idx_next   = '0;
        state_next = S_AN;
      end
      S_AN: begin
        op         = OP_MAC_AN;
        state_next = S_AH;
      end
      S_AH: begin
        op         = OP_MAC_AH;
        state_next = S_BN;
      end
      S_BN: begin
        op         = OP_MAC_BN;
        state_next = S_BH;
      end
      S_BH: begin
        op         = OP_MAC_BH;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (status.pt_zero) begin
          state_next = S_NEXT;
        end else begin
          op         = OP_DIV_AP;
          state_next = S_AP_W;
        end
      end
      S_AP_W: begin
        if (status.div_done) begin
          op         = OP_TAKE_AP;
          state_next = S_CK2;
        end
      end
      S_CK2: begin
        if (status.c_skip) begin
          state_next = S_NEXT;
        end else begin
          op         = OP_DIV_C;
          state_next = S_C_W;
        end
      end
      S_C_W: begin
        if (status.div_done) begin
          op         = OP_TAKE_C;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx == LAST) begin
          state_next = S_KS;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_AN;
        end
      end
      S_KS: begin
        op         = OP_DIV_K;
        state_next = S_K_W;
      end
      S_K_W: begin
        if (status.div_done) begin
          op         = OP_CEIL;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (push) begin
          op         = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, compartment index and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
